>>> hdl/tcdw_pkg.sv
// tcdw_pkg: shared constants and types for the decimal text cell writer.
// No dependencies.
package tcdw_pkg;

	localparam int unsigned COLUMNS = 80;

	localparam int VALUE_W  = 32;
	localparam int ATTR_W   = 8;
	localparam int ROW_W    = 5;
	localparam int COL_W    = 7;
	localparam int OFFS_W   = 12;
	localparam int CHAR_W   = 8;
	localparam int NDIG_W   = 4;
	localparam int POS_W    = 8;
	localparam int DIGIT_W  = 4;

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

	// floor(x/10) = (x * RECIP) >> SHIFT, exact over 32 bits
	localparam logic [VALUE_W-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
	localparam int                 DIV10_SHIFT = 35;

	typedef struct packed {
		logic [VALUE_W-1:0] quot;
		logic [DIGIT_W-1:0] digit;
		logic               zero;
	} div10_res_t;

endpackage

>>> hdl/tcdw_div10.sv
// tcdw_div10: divide-by-ten unit, quotient and remainder digit.
// Depends on tcdw_pkg.
module tcdw_div10
	import tcdw_pkg::*;
(
	input  logic [VALUE_W-1:0] dividend,
	output div10_res_t         res
);

	logic [2*VALUE_W-1:0] prod;
	logic [VALUE_W-1:0]   quot;
	logic [VALUE_W-1:0]   rem;

	assign prod = {{VALUE_W{1'b0}}, dividend} * {{VALUE_W{1'b0}}, DIV10_RECIP};
	assign quot = {{(DIV10_SHIFT-VALUE_W){1'b0}}, prod[2*VALUE_W-1:DIV10_SHIFT]};
	assign rem  = dividend - {quot[VALUE_W-4:0], 3'b000} - {quot[VALUE_W-2:0], 1'b0};

	assign res.quot  = quot;
	assign res.digit = rem[DIGIT_W-1:0];
	assign res.zero  = (quot == '0);

endmodule

>>> hdl/text_cell_decimal_writer.sv
// text_cell_decimal_writer: renders a signed integer as decimal text cell writes.
// Depends on tcdw_pkg and tcdw_div10.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_stall   | value, attribute, row, column
//   out     | output    | out_valid / out_stall | cell_offset, character, attribute_out, last
//
// Each number goes through two phases (ndig = digit count, 1..10): ndig passes
// of the shared divide-by-ten unit count the digits; then the sign, if negative,
// is written, and one digit per pass of the same unit.
// in_stall is high from acceptance until the last write is loaded.
// out_stall holds the output register; the sequencer waits with it.
// arst_n clears the sequencer and output valid.
module text_cell_decimal_writer
	import tcdw_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [VALUE_W-1:0]  value,
	input  logic [ATTR_W-1:0]   attribute,
	input  logic [ROW_W-1:0]    row,
	input  logic [COL_W-1:0]    column,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [OFFS_W-1:0]   cell_offset,
	output logic [CHAR_W-1:0]   character,
	output logic [ATTR_W-1:0]   attribute_out,
	output logic                last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COUNT,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [VALUE_W-1:0] work_q;
	logic [VALUE_W-1:0] mag_q;
	logic               neg_q;
	logic [ATTR_W-1:0]  attr_q;
	logic [OFFS_W-1:0]  base_q;
	logic [COL_W-1:0]   col_q;
	logic [NDIG_W-1:0]  ndig_q;
	logic [POS_W-1:0]   pos_q;
	logic               out_valid_q;
	logic [OFFS_W-1:0]  offs_q;
	logic [CHAR_W-1:0]  char_q;
	logic [ATTR_W-1:0]  attr_out_q;
	logic               last_q;

	div10_res_t         div_res;
	logic [VALUE_W-1:0] in_mag;
	logic [OFFS_W-1:0]  row_base;
	logic               in_take;
	logic               out_free;
	logic [OFFS_W-1:0]  sign_sum;
	logic [OFFS_W-1:0]  digit_sum;

	tcdw_div10 u_div10 (
		.dividend(work_q),
		.res     (div_res)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_mag   = value[VALUE_W-1] ? (~value + 1'b1) : value;
	assign row_base = OFFS_W'(row * COLUMNS);
	assign sign_sum  = base_q + {{(OFFS_W-COL_W){1'b0}}, col_q};
	assign digit_sum = base_q + {{(OFFS_W-POS_W){1'b0}}, pos_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_EMIT && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						work_q  <= in_mag;
						mag_q   <= in_mag;
						neg_q   <= value[VALUE_W-1];
						attr_q  <= attribute;
						base_q  <= row_base;
						col_q   <= column;
						ndig_q  <= '0;
						state_q <= ST_COUNT;
					end
				end
				ST_COUNT: begin
					ndig_q <= ndig_q + 1'b1;
					if (div_res.zero) begin
						work_q  <= mag_q;
						pos_q   <= {1'b0, col_q} + {{(POS_W-1){1'b0}}, neg_q}
						           + {{(POS_W-NDIG_W){1'b0}}, ndig_q};
						state_q <= ST_EMIT;
					end else begin
						work_q  <= div_res.quot;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						attr_out_q  <= attr_q;
						if (neg_q) begin
							neg_q  <= 1'b0;
							offs_q <= {sign_sum[OFFS_W-2:0], 1'b0};
							char_q <= CHAR_MINUS;
							last_q <= 1'b0;
						end else begin
							offs_q <= {digit_sum[OFFS_W-2:0], 1'b0};
							char_q <= CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, div_res.digit};
							last_q <= div_res.zero;
							work_q <= div_res.quot;
							pos_q  <= pos_q - 1'b1;
							if (div_res.zero)
								state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign cell_offset   = offs_q;
	assign character     = char_q;
	assign attribute_out = attr_out_q;
	assign last          = last_q;

endmodule

>>> hdl/tcdw_checker.sv
// tcdw_port_props: port-level assertions for text_cell_decimal_writer, and its bind.
// Depends on tcdw_pkg.
module tcdw_port_props
	import tcdw_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [OFFS_W-1:0]   cell_offset,
	input logic [CHAR_W-1:0]   character,
	input logic [ATTR_W-1:0]   attribute_out,
	input logic                last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cell_offset)
			&& $stable(character) && $stable(attribute_out) && $stable(last))
		else $error("stalled output item changed");

	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (character == CHAR_MINUS)
			|| (character >= CHAR_ZERO && character <= CHAR_NINE))
		else $error("character outside sign and digits");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && character == CHAR_MINUS |-> !last)
		else $error("minus sign flagged as last");

	a_even_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !cell_offset[0])
		else $error("odd cell offset");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after accept");

endmodule

bind text_cell_decimal_writer tcdw_port_props u_tcdw_port_props (.*);

>>> dv/tcdw_checker.sv
// tcdw_checker: watches both channels of text_cell_decimal_writer, predicts the cell writes
// for each accepted number and compares every accepted write in order.
// Depends on tcdw_pkg.
`timescale 1ns / 100ps

module tcdw_checker
	import tcdw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [VALUE_W-1:0] value,
	input  logic [ATTR_W-1:0]  attribute,
	input  logic [ROW_W-1:0]   row,
	input  logic [COL_W-1:0]   column,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [OFFS_W-1:0]  cell_offset,
	input  logic [CHAR_W-1:0]  character,
	input  logic [ATTR_W-1:0]  attribute_out,
	input  logic               last,
	output int                 mismatches,
	output int                 outstanding,
	output int                 numbers_taken,
	output int                 cells_taken
);

	typedef struct packed {
		logic [OFFS_W-1:0] offset;
		logic [CHAR_W-1:0] ch;
		logic [ATTR_W-1:0] attr;
		logic              fin;
	} cell_write_t;

	cell_write_t writes_due[$];

	initial begin
		mismatches    = 0;
		outstanding   = 0;
		numbers_taken = 0;
		cells_taken   = 0;
	end

	task automatic flag_mismatch(input string msg);
		$display("%0t ns: ERROR %s", $time, msg);
		mismatches++;
	endtask

	function automatic logic [OFFS_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
		input int unsigned c);
		int unsigned lin;
		lin = (r * COLUMNS + c) * 2;
		return lin[OFFS_W-1:0];
	endfunction

	// sign first, then digits from least significant at falling columns
	task automatic render_cells(input logic [VALUE_W-1:0] v, input logic [ATTR_W-1:0] a,
		input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
		logic [VALUE_W-1:0] mag;
		logic [VALUE_W-1:0] t;
		int unsigned digits;
		int unsigned pos;
		int unsigned k;
		pos = 32'(c);
		mag = v[VALUE_W-1] ? -v : v;
		digits = 0;
		t = mag;
		do begin
			digits++;
			t = t / 10;
		end while (t != 0);
		if (v[VALUE_W-1]) begin
			writes_due.push_back(cell_write_t'{cell_addr(r, pos), CHAR_MINUS, a, 1'b0});
			pos++;
		end
		pos = pos + digits - 1;
		for (k = 0; k < digits; k++) begin
			writes_due.push_back(cell_write_t'{cell_addr(r, pos), CHAR_ZERO + 8'(mag % 10), a,
				k + 1 == digits});
			mag = mag / 10;
			pos--;
		end
	endtask

	always @(posedge clk) begin : watch
		cell_write_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				render_cells(value, attribute, row, column);
				numbers_taken++;
			end
			if (out_valid && !out_stall) begin
				cells_taken++;
				if (writes_due.size() == 0) begin
					flag_mismatch($sformatf("cell write at %0h with nothing expected", cell_offset));
				end else begin
					want = writes_due.pop_front();
					if (cell_offset !== want.offset)
						flag_mismatch($sformatf("cell_offset %0h, expected %0h",
							cell_offset, want.offset));
					if (character !== want.ch)
						flag_mismatch($sformatf("character %0h, expected %0h", character, want.ch));
					if (attribute_out !== want.attr)
						flag_mismatch($sformatf("attribute_out %0h, expected %0h",
							attribute_out, want.attr));
					if (last !== want.fin)
						flag_mismatch($sformatf("last %0b, expected %0b", last, want.fin));
				end
			end
			outstanding = writes_due.size();
		end
	end

endmodule

>>> dv/tb_text_cell_decimal_writer.sv
// tb_text_cell_decimal_writer: stimulus, receiver stalls and verdict for the decimal text
// cell writer. Depends on tcdw_pkg, text_cell_decimal_writer and tcdw_checker.
`timescale 1ns / 100ps

module tb_text_cell_decimal_writer;
	import tcdw_pkg::*;

	localparam int RANDOM_NUMBERS  = 410;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int DRAIN_CYCLES    = 40;
	localparam int CYCLE_LIMIT     = 500000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [VALUE_W-1:0] value = '0;
	logic [ATTR_W-1:0]  attribute = '0;
	logic [ROW_W-1:0]   row = '0;
	logic [COL_W-1:0]   column = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [OFFS_W-1:0]  cell_offset;
	logic [CHAR_W-1:0]  character;
	logic [ATTR_W-1:0]  attribute_out;
	logic               last;

	int          mismatches;
	int          outstanding;
	int          numbers_taken;
	int          cells_taken;
	int unsigned cycles = 0;
	bit          hold_off_req = 1'b0;

	text_cell_decimal_writer i_dut (.*);

	tcdw_checker i_checker (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("text_cell_decimal_writer: mismatch");
			$finish;
		end
	end

	task automatic offer(input logic [VALUE_W-1:0] v, input logic [ATTR_W-1:0] a,
		input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
		in_valid  <= 1'b1;
		value     <= v;
		attribute <= a;
		row       <= r;
		column    <= c;
		do @(posedge clk); while (in_stall);
	endtask

	// digit count picked first so short and long numbers are equally likely, but for a 1-in-16 fully random value
	task automatic pick_number(output logic [VALUE_W-1:0] v, output logic [ATTR_W-1:0] a,
		output logic [ROW_W-1:0] r, output logic [COL_W-1:0] c);
		int digits;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mag;
		if ($urandom_range(0, 15) == 0) begin
			v = $urandom;
		end else begin
			digits = $urandom_range(1, 10);
			lo = 1;
			repeat (digits - 1) lo = lo * 10;
			hi = lo * 10 - 1;
			if (digits == 1) lo = 0;
			if (hi > 64'd2147483647) hi = 64'd2147483647;
			mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
			v = mag[VALUE_W-1:0];
			if ($urandom_range(0, 1) == 1) v = -v;
		end
		a = 8'($urandom_range(0, 255));
		r = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, 24));
		c = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 79));
	endtask

	initial begin : receiver
		int mode;
		int span;
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				span = $urandom_range(8, 60);
				repeat (span) begin
					case (mode)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 1) == 1);
						2: out_stall <= ($urandom_range(0, 3) != 0);
						default: out_stall <= ($urandom_range(0, 7) == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	initial begin : stimulus
		logic [VALUE_W-1:0] v;
		logic [ATTR_W-1:0]  a;
		logic [ROW_W-1:0]   r;
		logic [COL_W-1:0]   c;
		int sent;
		int burst;
		int pause;
		int k;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(32'd0, 8'h00, 5'd0, 7'd0);
		offer(32'd0, 8'hFF, 5'd31, 7'd127);
		offer(32'd1, 8'h01, 5'd1, 7'd1);
		offer(-32'sd1, 8'h80, 5'd2, 7'd78);
		offer(32'd9, 8'h07, 5'd24, 7'd79);
		offer(32'd10, 8'h70, 5'd10, 7'd0);
		offer(-32'sd10, 8'h1E, 5'd0, 7'd79);
		offer(32'd99, 8'hE1, 5'd16, 7'd64);
		offer(-32'sd100, 8'h55, 5'd8, 7'd32);
		offer(32'sd2147483647, 8'hAA, 5'd24, 7'd79);
		offer(32'h8000_0000, 8'h0F, 5'd0, 7'd0);
		offer(-32'sd2147483647, 8'hF0, 5'd31, 7'd127);
		offer(32'd1000000000, 8'h3C, 5'd4, 7'd70);
		offer(32'd999999999, 8'hC3, 5'd20, 7'd5);
		offer(-32'sd999999999, 8'h5A, 5'd12, 7'd40);
		offer(32'd1234567890, 8'hA5, 5'd12, 7'd40);
		offer(-32'sd5, 8'h00, 5'd31, 7'd127);
		offer(32'd7, 8'hFF, 5'd24, 7'd127);
		offer(-32'sd1000000000, 8'h81, 5'd31, 7'd0);
		offer(32'd42, 8'h7E, 5'd0, 7'd127);
		in_valid <= 1'b0;

		hold_off_req = 1'b1;
		sent = 0;
		while (sent < RANDOM_NUMBERS) begin
			burst = $urandom_range(1, 12);
			for (k = 0; k < burst && sent < RANDOM_NUMBERS; k++) begin
				if (sent == RANDOM_NUMBERS / 2) hold_off_req = 1'b1;
				pick_number(v, a, r, c);
				offer(v, a, r, c);
				sent++;
			end
			pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (pause > 0) begin
				in_valid <= 1'b0;
				repeat (pause) @(posedge clk);
			end
		end
		in_valid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Rendered %0d numbers into %0d cell writes: zero, both 32-bit extremes,",
			numbers_taken, cells_taken);
		$display("every digit count, off-screen rows and columns, two long output hold-offs.");
		if (mismatches == 0)
			$display("text_cell_decimal_writer: match");
		else
			$display("text_cell_decimal_writer: mismatch");
		$finish;
	end

endmodule

>>> files.f
hdl/tcdw_pkg.sv
hdl/tcdw_div10.sv
hdl/text_cell_decimal_writer.sv
hdl/tcdw_checker.sv
dv/tcdw_checker.sv
dv/tb_text_cell_decimal_writer.sv
